// File: rtl/carp_pkg.sv
// ----------------------------------------------------------------------------
// carp_pkg
// Shared types, widths, register indexes and saturation helpers for the
// cascaded attitude / rate PI controller.
// ----------------------------------------------------------------------------
package carp_pkg;

    localparam int SIG_W   = 16;      // Q4.12 signal width
    localparam int RI_W    = 24;      // rate integrator width
    localparam int ERR_W   = SIG_W + 1;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 48;
    localparam int MA_W    = RI_W + 1;
    localparam int MB_W    = GAIN_W + 2;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int WIDE_W  = 54;
    localparam int EX_W    = 35;
    localparam int EX_SPLIT = 17;

    localparam int PI_Q12       = 12868;
    localparam int TWO_PI_Q12   = 25736;
    localparam int ATT_INT_LIM  = 20480;

    localparam logic [15:0] STEP_PERIOD_RST = 16'd66;
    localparam logic [15:0] LOWPASS_RST     = 16'd6554;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [MA_W-1:0]   mula_t;
    typedef logic signed [MB_W-1:0]   mulb_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [SIG_W-1:0]  sig_t;
    typedef logic signed [RI_W-1:0]   rint_t;

    typedef enum logic [2:0] {
        CFG_ATT_KP     = 3'd0,
        CFG_ATT_KI     = 3'd1,
        CFG_RATE_KP    = 3'd2,
        CFG_RATE_KI    = 3'd3,
        CFG_TRQ_LIM    = 3'd4,
        CFG_STEP       = 3'd5,
        CFG_LOWPASS    = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRAP,
        ST_AI_MUL,
        ST_AI_UPD,
        ST_KP_MUL,
        ST_KI_MUL,
        ST_DES,
        ST_RI_MUL,
        ST_RI_UPD,
        ST_RKP_MUL,
        ST_RKI_MUL,
        ST_UCALC,
        ST_EXLO_MUL,
        ST_EXHI_MUL,
        ST_BLEED_ACC,
        ST_BLEED,
        ST_LP_MUL,
        ST_F_UPD,
        ST_DONE
    } state_t;

    function automatic sig_t sat_sig(input wide_t x);
        wide_t hi;
        wide_t lo;
        hi = wide_t'((2 ** (SIG_W - 1)) - 1);
        lo = -hi - wide_t'(1);
        if (x > hi)
            return sig_t'(hi);
        else if (x < lo)
            return sig_t'(lo);
        else
            return sig_t'(x);
    endfunction

    function automatic rint_t sat_ri(input wide_t x);
        wide_t hi;
        wide_t lo;
        hi = wide_t'((2 ** (RI_W - 1)) - 1);
        lo = -hi - wide_t'(1);
        if (x > hi)
            return rint_t'(hi);
        else if (x < lo)
            return rint_t'(lo);
        else
            return rint_t'(x);
    endfunction

    function automatic logic [GAIN_W-1:0] field16(input logic [CFG_W-1:0] r,
                                                  input logic [1:0] axis);
        return r[axis*GAIN_W +: GAIN_W];
    endfunction

endpackage

// File: rtl/cascaded_attitude_rate_pid.sv
// Each axis takes 16 sequencer steps plus 1 to 4 angle-wrap steps, and one
// step loads the result. A new sample is taken only in idle, once the last
// result has loaded past any output stall; a single 25x18 multiplier is
// shared by all products, walking each axis through in turn.
// Reset clears integrators and filters, sets yaw hold, loads register defaults.
// ----------------------------------------------------------------------------
// cascaded_attitude_rate_pid
// Three-axis cascaded PI attitude / rate controller with back-calculation
// anti-windup and first-order actuator filter, sequenced over one multiplier.
// ----------------------------------------------------------------------------
module cascaded_attitude_rate_pid (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_index,
    input  logic [carp_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [15:0]           roll_cmd,
    input  logic signed [15:0]           pitch_cmd,
    input  logic signed [15:0]           yaw_cmd,
    input  logic signed [15:0]           yaw_rate_sp,
    input  logic signed [15:0]           roll_angle,
    input  logic signed [15:0]           pitch_angle,
    input  logic signed [15:0]           yaw_angle,
    input  logic signed [15:0]           roll_rate,
    input  logic signed [15:0]           pitch_rate,
    input  logic signed [15:0]           yaw_rate,
    input  logic                         armed,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [15:0]           torque_x,
    output logic signed [15:0]           torque_y,
    output logic signed [15:0]           torque_z
);

    carp_pkg::state_t state_reg, state_next;

    logic [carp_pkg::CFG_W-1:0] att_kp_reg, att_ki_reg, rate_kp_reg, rate_ki_reg, lim_reg;
    logic [15:0]                step_reg, lpc_reg;

    carp_pkg::sig_t  ai_reg   [3];
    carp_pkg::rint_t ri_reg   [3];
    carp_pkg::sig_t  f_reg    [3];
    carp_pkg::err_t  err_reg  [3];
    carp_pkg::sig_t  rate_reg [3];
    carp_pkg::sig_t  tq_reg   [3];
    logic            hold_reg;
    carp_pkg::sig_t  yrc_reg;
    logic            armed_reg;
    logic [1:0]      axis_reg;

    carp_pkg::sig_t  re_reg, uc_reg;
    logic signed [carp_pkg::EX_W-1:0] ex_reg;
    carp_pkg::wide_t acc_reg;
    carp_pkg::prod_t prod_reg;
    logic            out_valid_reg;
    carp_pkg::sig_t  tx_reg, ty_reg, tz_reg;

    carp_pkg::mula_t mul_a;
    carp_pkg::mulb_t mul_b;

    // per-axis working values
    carp_pkg::err_t  e_cur;
    carp_pkg::wide_t prod_w, rnd16, dt_w;
    carp_pkg::wide_t lim_w, p_sum, p_rnd8, ai_sum, u_cl, des_w, f_sum, f_cl;
    carp_pkg::sig_t  ai_new, des, re_new, uc_new, f_new;
    carp_pkg::rint_t ri_add, ri_bleed;
    logic            wrap_hi, wrap_lo, integ, in_acc, out_load;
    logic [15:0]     kp_f, ki_f, rkp_f, rki_f, lim_f;

    assign in_stall  = (state_reg != carp_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign torque_x  = tx_reg;
    assign torque_y  = ty_reg;
    assign torque_z  = tz_reg;
    assign out_load  = (state_reg == carp_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    assign kp_f  = carp_pkg::field16(att_kp_reg, axis_reg);
    assign ki_f  = carp_pkg::field16(att_ki_reg, axis_reg);
    assign rkp_f = carp_pkg::field16(rate_kp_reg, axis_reg);
    assign rki_f = carp_pkg::field16(rate_ki_reg, axis_reg);
    assign lim_f = carp_pkg::field16(lim_reg, axis_reg);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            carp_pkg::ST_IDLE:      if (in_acc) state_next = carp_pkg::ST_WRAP;
            carp_pkg::ST_WRAP:      if (!wrap_hi && !wrap_lo) state_next = carp_pkg::ST_AI_MUL;
            carp_pkg::ST_AI_MUL:    state_next = carp_pkg::ST_AI_UPD;
            carp_pkg::ST_AI_UPD:    state_next = carp_pkg::ST_KP_MUL;
            carp_pkg::ST_KP_MUL:    state_next = carp_pkg::ST_KI_MUL;
            carp_pkg::ST_KI_MUL:    state_next = carp_pkg::ST_DES;
            carp_pkg::ST_DES:       state_next = carp_pkg::ST_RI_MUL;
            carp_pkg::ST_RI_MUL:    state_next = carp_pkg::ST_RI_UPD;
            carp_pkg::ST_RI_UPD:    state_next = carp_pkg::ST_RKP_MUL;
            carp_pkg::ST_RKP_MUL:   state_next = carp_pkg::ST_RKI_MUL;
            carp_pkg::ST_RKI_MUL:   state_next = carp_pkg::ST_UCALC;
            carp_pkg::ST_UCALC:     state_next = carp_pkg::ST_EXLO_MUL;
            carp_pkg::ST_EXLO_MUL:  state_next = carp_pkg::ST_EXHI_MUL;
            carp_pkg::ST_EXHI_MUL:  state_next = carp_pkg::ST_BLEED_ACC;
            carp_pkg::ST_BLEED_ACC: state_next = carp_pkg::ST_BLEED;
            carp_pkg::ST_BLEED:     state_next = carp_pkg::ST_LP_MUL;
            carp_pkg::ST_LP_MUL:    state_next = carp_pkg::ST_F_UPD;
            carp_pkg::ST_F_UPD:
                state_next = (axis_reg == 2'd2) ? carp_pkg::ST_DONE : carp_pkg::ST_WRAP;
            carp_pkg::ST_DONE:      if (out_load) state_next = carp_pkg::ST_IDLE;
            default:                state_next = carp_pkg::ST_IDLE;
        endcase
    end

    // ---------------- multiplier operand select ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            carp_pkg::ST_AI_MUL:
            begin
                mul_a = carp_pkg::mula_t'(e_cur);
                mul_b = $signed({2'b00, step_reg});
            end
            carp_pkg::ST_KP_MUL:
            begin
                mul_a = carp_pkg::mula_t'(e_cur);
                mul_b = $signed({2'b00, kp_f});
            end
            carp_pkg::ST_KI_MUL:
            begin
                mul_a = carp_pkg::mula_t'(ai_reg[axis_reg]);
                mul_b = $signed({2'b00, ki_f});
            end
            carp_pkg::ST_RI_MUL:
            begin
                mul_a = carp_pkg::mula_t'(re_reg);
                mul_b = $signed({2'b00, step_reg});
            end
            carp_pkg::ST_RKP_MUL:
            begin
                mul_a = carp_pkg::mula_t'(re_reg);
                mul_b = $signed({2'b00, rkp_f});
            end
            carp_pkg::ST_RKI_MUL:
            begin
                mul_a = carp_pkg::mula_t'(ri_reg[axis_reg]);
                mul_b = $signed({2'b00, rki_f});
            end
            carp_pkg::ST_EXLO_MUL:
            begin
                mul_a = $signed({{(carp_pkg::MA_W - carp_pkg::EX_SPLIT){1'b0}},
                                 ex_reg[carp_pkg::EX_SPLIT-1:0]});
                mul_b = $signed({1'b0, step_reg, 1'b0});
            end
            carp_pkg::ST_EXHI_MUL:
            begin
                mul_a = carp_pkg::mula_t'($signed(ex_reg[carp_pkg::EX_W-1:carp_pkg::EX_SPLIT]));
                mul_b = $signed({1'b0, step_reg, 1'b0});
            end
            carp_pkg::ST_LP_MUL:
            begin
                mul_a = carp_pkg::mula_t'(carp_pkg::wide_t'(uc_reg)
                                          - carp_pkg::wide_t'(f_reg[axis_reg]));
                mul_b = $signed({2'b00, lpc_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- datapath arithmetic ----------------
    always_comb
    begin
        e_cur   = err_reg[axis_reg];
        wrap_hi = (e_cur > carp_pkg::err_t'(carp_pkg::PI_Q12));
        wrap_lo = (e_cur <= -carp_pkg::err_t'(carp_pkg::PI_Q12));
        prod_w  = carp_pkg::wide_t'(prod_reg);
        dt_w    = carp_pkg::wide_t'(step_reg);
        rnd16   = (prod_w + carp_pkg::wide_t'(32768)) >>> 16;
        lim_w   = carp_pkg::wide_t'(lim_f);

        // attitude integrator, clamped to +/-5.0
        integ  = armed_reg && !((axis_reg == 2'd2) && (yrc_reg != '0));
        ai_sum = carp_pkg::wide_t'(ai_reg[axis_reg]) + (integ ? rnd16 : '0);
        if (ai_sum > carp_pkg::wide_t'(carp_pkg::ATT_INT_LIM))
            ai_sum = carp_pkg::wide_t'(carp_pkg::ATT_INT_LIM);
        else if (ai_sum < -carp_pkg::wide_t'(carp_pkg::ATT_INT_LIM))
            ai_sum = -carp_pkg::wide_t'(carp_pkg::ATT_INT_LIM);
        ai_new = carp_pkg::sig_t'(ai_sum);

        // shared PI sum for both loops: acc holds the kp term
        p_sum  = acc_reg + prod_w;
        p_rnd8 = (p_sum + carp_pkg::wide_t'(128)) >>> 8;

        des = carp_pkg::sat_sig(p_rnd8);
        if (axis_reg == 2'd2 && yrc_reg != '0)
            des = yrc_reg;
        else if (axis_reg == 2'd2 && hold_reg)
            des = rate_reg[2];
        des_w  = carp_pkg::wide_t'(des) - carp_pkg::wide_t'(rate_reg[axis_reg]);
        re_new = carp_pkg::sat_sig(des_w);

        ri_add = carp_pkg::sat_ri(carp_pkg::wide_t'(ri_reg[axis_reg]) + rnd16);

        u_cl = p_rnd8;
        if (u_cl > lim_w)
            u_cl = lim_w;
        else if (u_cl < -lim_w)
            u_cl = -lim_w;
        uc_new = carp_pkg::sat_sig(u_cl);

        // acc holds 2*excess*dt after the split multiply
        ri_bleed = carp_pkg::sat_ri(carp_pkg::wide_t'(ri_reg[axis_reg])
                   - ((acc_reg + carp_pkg::wide_t'(32768)) >>> 16));

        f_sum = carp_pkg::wide_t'(f_reg[axis_reg]) + rnd16;
        f_new = carp_pkg::sat_sig(f_sum);
        f_cl  = carp_pkg::wide_t'(f_new);
        if (f_cl > lim_w)
            f_cl = lim_w;
        else if (f_cl < -lim_w)
            f_cl = -lim_w;
        // zero step period freezes the bleed
        if (dt_w == '0)
            ri_bleed = ri_reg[axis_reg];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= carp_pkg::ST_IDLE;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b1;
            att_kp_reg    <= '0;
            att_ki_reg    <= '0;
            rate_kp_reg   <= '0;
            rate_ki_reg   <= '0;
            lim_reg       <= '0;
            step_reg      <= carp_pkg::STEP_PERIOD_RST;
            lpc_reg       <= carp_pkg::LOWPASS_RST;
            for (int i = 0; i < 3; i++)
            begin
                ai_reg[i] <= '0;
                ri_reg[i] <= '0;
                f_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    carp_pkg::CFG_ATT_KP:  att_kp_reg  <= cfg_data;
                    carp_pkg::CFG_ATT_KI:  att_ki_reg  <= cfg_data;
                    carp_pkg::CFG_RATE_KP: rate_kp_reg <= cfg_data;
                    carp_pkg::CFG_RATE_KI: rate_ki_reg <= cfg_data;
                    carp_pkg::CFG_TRQ_LIM: lim_reg     <= cfg_data;
                    carp_pkg::CFG_STEP:    step_reg    <= cfg_data[15:0];
                    carp_pkg::CFG_LOWPASS: lpc_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_acc)
            begin
                axis_reg <= 2'd0;
                if (yaw_rate_sp != '0)
                    hold_reg <= 1'b0;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                carp_pkg::ST_AI_UPD: ai_reg[axis_reg] <= ai_new;
                carp_pkg::ST_RI_UPD: ri_reg[axis_reg] <= ri_add;
                carp_pkg::ST_BLEED:  ri_reg[axis_reg] <= ri_bleed;
                carp_pkg::ST_F_UPD:
                begin
                    f_reg[axis_reg] <= f_new;
                    if (axis_reg != 2'd2)
                        axis_reg <= axis_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (in_acc)
        begin
            err_reg[0]  <= carp_pkg::err_t'(roll_cmd) - carp_pkg::err_t'(roll_angle);
            err_reg[1]  <= carp_pkg::err_t'(pitch_cmd) - carp_pkg::err_t'(pitch_angle);
            err_reg[2]  <= carp_pkg::err_t'(yaw_cmd) - carp_pkg::err_t'(yaw_angle);
            rate_reg[0] <= roll_rate;
            rate_reg[1] <= pitch_rate;
            rate_reg[2] <= yaw_rate;
            yrc_reg     <= yaw_rate_sp;
            armed_reg   <= armed;
        end

        unique case (state_reg)
            carp_pkg::ST_WRAP:
            begin
                if (wrap_hi)
                    err_reg[axis_reg] <= e_cur - carp_pkg::err_t'(carp_pkg::TWO_PI_Q12);
                else if (wrap_lo)
                    err_reg[axis_reg] <= e_cur + carp_pkg::err_t'(carp_pkg::TWO_PI_Q12);
            end
            carp_pkg::ST_KI_MUL,
            carp_pkg::ST_RKI_MUL,
            carp_pkg::ST_EXHI_MUL: acc_reg <= prod_w;
            carp_pkg::ST_BLEED_ACC: acc_reg <= acc_reg + (prod_w <<< carp_pkg::EX_SPLIT);
            carp_pkg::ST_DES:      re_reg  <= re_new;
            carp_pkg::ST_UCALC:
            begin
                uc_reg <= uc_new;
                ex_reg <= carp_pkg::EX_W'(p_rnd8 - carp_pkg::wide_t'(uc_new));
            end
            carp_pkg::ST_F_UPD:    tq_reg[axis_reg] <= carp_pkg::sig_t'(f_cl);
            default: ;
        endcase

        if (out_load)
        begin
            tx_reg <= tq_reg[0];
            ty_reg <= tq_reg[1];
            tz_reg <= tq_reg[2];
        end
    end

    // ---------------- assertions ----------------
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    a_att_int_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ai_reg[0] <= 16'sd20480) && (ai_reg[0] >= -16'sd20480) &&
        (ai_reg[1] <= 16'sd20480) && (ai_reg[1] >= -16'sd20480) &&
        (ai_reg[2] <= 16'sd20480) && (ai_reg[2] >= -16'sd20480))
        else $error("attitude integrator beyond clamp");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != carp_pkg::ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && state_reg != carp_pkg::ST_DONE) |=> !out_valid)
        else $error("result beat repeated");

    a_hold_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !hold_reg |=> !hold_reg)
        else $error("yaw hold set again without reset");

endmodule
